// ===== hdl/fir_q8_pkg.sv =====
// ----------------------------------------------------------------------------
// fir_q8_pkg
// Types and constants shared by the ten-tap symmetric Q8 FIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package fir_q8_pkg;

  localparam int TAPS        = 10;
  localparam int NCOEF       = TAPS / 2;
  localparam int COEF_W      = 9;
  localparam int OUT_W       = 20;
  localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;
  localparam int CFG_IDX_W   = 3;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_OUTER  = 3'd0,
    CFG_COEF_SECOND = 3'd1,
    CFG_COEF_THIRD  = 3'd2,
    CFG_COEF_FOURTH = 3'd3,
    CFG_COEF_CENTER = 3'd4
  } cfg_reg_t;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [NCOEF-1:0]        coef_set_t;

  localparam coef_t COEF_OUTER_RST  = 9'sd2;
  localparam coef_t COEF_SECOND_RST = 9'sd8;
  localparam coef_t COEF_THIRD_RST  = 9'sd22;
  localparam coef_t COEF_FOURTH_RST = 9'sd40;
  localparam coef_t COEF_CENTER_RST = 9'sd53;

  // tap k and tap TAPS-1-k share one coefficient
  function automatic int coef_sel(input int k);
    coef_sel = (k < TAPS - 1 - k) ? k : (TAPS - 1 - k);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/fir_q8_front.sv =====
// ----------------------------------------------------------------------------
// fir_q8_front
// Accepts samples, advances the delay line and emits the ten-sample window.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_q8_front #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int WIN_W        = 10 * SAMPLE_WIDTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [SAMPLE_WIDTH-1:0] sample,
  output logic                         push_valid,
  input  wire logic                    push_ready,
  output logic [WIN_W-1:0]             push_data
);
  import fir_q8_pkg::*;

  logic [SAMPLE_WIDTH-1:0] dl_r   [TAPS-1];
  logic [SAMPLE_WIDTH-1:0] dl_nxt [TAPS-1];
  logic                    accept;

  assign in_tready  = push_ready;
  assign push_valid = in_tvalid;
  assign accept     = in_tvalid && push_ready;

  always_comb begin
    push_data[SAMPLE_WIDTH-1:0] = sample;
    for (int k = 1; k < TAPS; k++) begin
      push_data[k*SAMPLE_WIDTH +: SAMPLE_WIDTH] = dl_r[k-1];
    end
  end

  always_comb begin
    dl_nxt[0] = sample;
    for (int k = 1; k < TAPS - 1; k++) begin
      dl_nxt[k] = dl_r[k-1];
    end
  end

  // history clears at reset so missing taps add nothing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TAPS - 1; k++) dl_r[k] <= '0;
    end else if (accept) begin
      for (int k = 0; k < TAPS - 1; k++) dl_r[k] <= dl_nxt[k];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/fir_q8_queue.sv =====
// ----------------------------------------------------------------------------
// fir_q8_queue
// Two-entry queue between front and back; each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_q8_queue #(
  parameter int DATA_W = 160
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output logic [DATA_W-1:0]      pop_data
);
  import fir_q8_pkg::*;

  logic [DATA_W-1:0] mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push, pop;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> pop_valid)
    else $error("pushed entry not visible");

endmodule

`default_nettype wire

// ===== hdl/fir_q8_back.sv =====
// ----------------------------------------------------------------------------
// fir_q8_back
// Tap multipliers, two-level adder and saturation, with the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_q8_back #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int WIN_W        = 10 * SAMPLE_WIDTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire fir_q8_pkg::coef_set_t   coefs,
  input  wire logic                    win_valid,
  output logic                         win_ready,
  input  wire logic [WIN_W-1:0]        win_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [fir_q8_pkg::OUT_W-1:0] result
);
  import fir_q8_pkg::*;

  localparam int SW     = SAMPLE_WIDTH;
  localparam int MUL_W  = SW + 5;
  localparam int PROD_W = SW + 1;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PAIR_W + 3;
  localparam int EXT_W  = (SUM_W > OUT_W) ? SUM_W : OUT_W;
  localparam int NPAIR  = TAPS / 2;

  logic                     adv;
  logic                     v1_r, v2_r, vo_r;
  logic signed [PROD_W-1:0] prod_r   [TAPS];
  logic signed [PROD_W-1:0] prod_nxt [TAPS];
  logic signed [PAIR_W-1:0] pair_r   [NPAIR];
  logic signed [PAIR_W-1:0] pair_nxt [NPAIR];
  logic signed [SUM_W-1:0]  total;
  logic signed [EXT_W-1:0]  total_ext;
  logic [EXT_W-OUT_W:0]     hi_bits;
  logic [OUT_W-1:0]         res_r, res_nxt;

  // whole pipeline holds while a finished result waits
  assign adv       = !vo_r || out_ready;
  assign win_ready = adv;
  assign out_valid = vo_r;
  assign result    = res_r;

  for (genvar k = 0; k < TAPS; k++) begin : g_tap
    logic signed [SW-4:0]     s_sh;
    logic signed [COEF_W-2:0] c_sh;
    logic signed [MUL_W-1:0]  full;
    assign s_sh = win_data[k*SW+3 +: SW-3];
    assign c_sh = coefs[coef_sel(k)][COEF_W-1:1];
    assign full = s_sh * c_sh;
    assign prod_nxt[k] = full[MUL_W-1:4];
  end

  always_comb begin
    for (int j = 0; j < NPAIR; j++) begin
      pair_nxt[j] = PAIR_W'(prod_r[2*j]) + PAIR_W'(prod_r[2*j+1]);
    end
  end

  always_comb begin
    total = '0;
    for (int j = 0; j < NPAIR; j++) begin
      total = total + SUM_W'(pair_r[j]);
    end
    total_ext = EXT_W'(total);
    hi_bits   = total_ext[EXT_W-1:OUT_W-1];
    // clamp to the output range when the upper bits disagree
    if ((&hi_bits) || !(|hi_bits)) begin
      res_nxt = total_ext[OUT_W-1:0];
    end else if (total_ext[EXT_W-1]) begin
      res_nxt = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      res_nxt = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < TAPS; k++) prod_r[k] <= prod_nxt[k];
      for (int j = 0; j < NPAIR; j++) pair_r[j] <= pair_nxt[j];
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (adv) begin
      v1_r <= win_valid;
      v2_r <= v1_r;
      vo_r <= v2_r;
    end
  end

  a_stage_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && adv |=> vo_r)
    else $error("summed transaction lost before output");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r && !out_ready |=> $stable(v1_r) && $stable(v2_r))
    else $error("pipeline moved during output stall");

endmodule

`default_nettype wire

// ===== hdl/fir_filter_fixed_point_q8.sv =====
// ----------------------------------------------------------------------------
// fir_filter_fixed_point_q8
// Ten-tap symmetric FIR filter, Q8 coefficients, one sample per transaction.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | slave     | in_tvalid/in_tready  | in_tdata: sample_in
//  out_    | master    | out_tvalid/out_tready| out_tdata: filtered_out
//  cfg_    | write     | cfg_wr_en            | cfg_index, cfg_wdata (coefficient)
//
//  One sample per cycle sustained while out_tready stays high. The path is
//  registered in the queue, tap multipliers, pair adders and saturated sum.
//  rst_n is synchronous: delay line cleared, coefficients back to defaults.
//  An output stall freezes the back pipeline; the two-entry queue keeps the
//  front accepting until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_filter_fixed_point_q8 #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // [SAMPLE_WIDTH-1:0] sample_in, zero fill to whole bytes
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     in_tdata,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // [19:0] filtered_out, [23:20] zero
  output logic [fir_q8_pkg::OUT_BYTES_W-1:0]         out_tdata,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [fir_q8_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [fir_q8_pkg::COEF_W-1:0]         cfg_wdata
);
  import fir_q8_pkg::*;

  localparam int WIN_W = TAPS * SAMPLE_WIDTH;

  coef_set_t          coefs_r;
  logic               push_valid, push_ready;
  logic [WIN_W-1:0]   push_data;
  logic               pop_valid, pop_ready;
  logic [WIN_W-1:0]   pop_data;
  logic [OUT_W-1:0]   result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coefs_r[CFG_COEF_OUTER]  <= COEF_OUTER_RST;
      coefs_r[CFG_COEF_SECOND] <= COEF_SECOND_RST;
      coefs_r[CFG_COEF_THIRD]  <= COEF_THIRD_RST;
      coefs_r[CFG_COEF_FOURTH] <= COEF_FOURTH_RST;
      coefs_r[CFG_COEF_CENTER] <= COEF_CENTER_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_COEF_OUTER:  coefs_r[CFG_COEF_OUTER]  <= cfg_wdata;
        CFG_COEF_SECOND: coefs_r[CFG_COEF_SECOND] <= cfg_wdata;
        CFG_COEF_THIRD:  coefs_r[CFG_COEF_THIRD]  <= cfg_wdata;
        CFG_COEF_FOURTH: coefs_r[CFG_COEF_FOURTH] <= cfg_wdata;
        CFG_COEF_CENTER: coefs_r[CFG_COEF_CENTER] <= cfg_wdata;
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  fir_q8_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .WIN_W        (WIN_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .sample     (in_tdata[SAMPLE_WIDTH-1:0]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  fir_q8_queue #(
    .DATA_W (WIN_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  fir_q8_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .WIN_W        (WIN_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .coefs     (coefs_r),
    .win_valid (pop_valid),
    .win_ready (pop_ready),
    .win_data  (pop_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .result    (result)
  );

  assign out_tdata = {{(OUT_BYTES_W-OUT_W){1'b0}}, result};

endmodule

`default_nettype wire

// ===== bench/fir_filter_fixed_point_q8_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fir_filter_fixed_point_q8_tb
// Self-checking bench for the ten-tap symmetric Q8 FIR filter. A local
// predictor tracks the delay line and the five coefficients and queues the
// expected filtered value for every sample accepted. Each result transaction
// is checked against the oldest queued value. Directed samples cover the
// defaults, empty history, field extremes and ignored register writes. Random
// coefficient settings follow, then a long output hold and a gap-free stream.
// ----------------------------------------------------------------------------

module fir_filter_fixed_point_q8_tb;

  import fir_q8_pkg::*;

  localparam int SW         = 16;
  localparam int IN_W       = ((SW + 7) / 8) * 8;
  localparam int LATENCY    = 4;
  localparam int LONG_HOLD  = 60;
  localparam longint OUT_MAX = (longint'(1) << (OUT_W - 1)) - 1;
  localparam longint OUT_MIN = -(longint'(1) << (OUT_W - 1));
  localparam coef_t COEF_MIN = coef_t'(-256);
  localparam coef_t COEF_MAX = coef_t'(255);
  localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  // [15:0] sample_in
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  // [19:0] filtered_out, [23:20] zero
  logic [OUT_BYTES_W-1:0] out_tdata;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0] cfg_wdata;

  fir_filter_fixed_point_q8 #(
    .SAMPLE_WIDTH(SW)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  coef_t                 coef_model [NCOEF];
  logic signed [SW-1:0]  history [TAPS-1];
  logic [OUT_W-1:0]      filtered_q [$];

  bit          src_gaps_on;
  bit          sink_stalls_on;
  bit          hold_request;
  int unsigned errors;
  int unsigned samples_sent;
  int unsigned results_checked;
  int unsigned settings_used;
  int unsigned in_stall_cycles;

  // Clamped sum of the ten truncated tap products, then shift the sample in.
  function automatic logic [OUT_W-1:0] filter_step(input logic signed [SW-1:0] x);
    longint acc;
    longint smp;
    longint cf;
    acc = 0;
    for (int k = 0; k < TAPS; k++) begin
      if (k == 0)
        smp = longint'(x);
      else
        smp = longint'(history[k-1]);
      cf = longint'(coef_model[(k < NCOEF) ? k : TAPS - 1 - k]);
      acc += ((smp >>> 3) * (cf >>> 1)) >>> 4;
    end
    for (int k = TAPS - 2; k > 0; k--)
      history[k] = history[k-1];
    history[0] = x;
    if (acc > OUT_MAX)
      acc = OUT_MAX;
    if (acc < OUT_MIN)
      acc = OUT_MIN;
    return acc[OUT_W-1:0];
  endfunction

  function automatic logic signed [SW-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return SW'($urandom_range(0, 64)) - SW'(32);
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic coef_t rand_coef();
    case ($urandom_range(0, 7))
      0: return COEF_MIN;
      1: return COEF_MAX;
      2: return '0;
      default: return coef_t'($urandom);
    endcase
  endfunction

  // Called at a falling edge with the input channel idle.
  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input coef_t val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    // out-of-range indexes leave the coefficients alone
    if (idx < NCOEF)
      coef_model[idx] = val;
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_coefs(input coef_t c_outer, input coef_t c_second,
                           input coef_t c_third, input coef_t c_fourth,
                           input coef_t c_center);
    write_coef(CFG_COEF_OUTER, c_outer);
    write_coef(CFG_COEF_SECOND, c_second);
    write_coef(CFG_COEF_THIRD, c_third);
    write_coef(CFG_COEF_FOURTH, c_fourth);
    write_coef(CFG_COEF_CENTER, c_center);
    settings_used++;
  endtask

  // Entered and left at a falling edge; valid stays up for a back-to-back item.
  task automatic send_sample(input logic signed [SW-1:0] x);
    if (src_gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= $unsigned(x);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    filtered_q.push_back(filter_step(x));
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic test_default_response();
    // impulse through empty history walks every tap at the reset coefficients
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    send_sample(SAMPLE_MAX);
    repeat (TAPS - 1) send_sample('0);
    wait_idle();
  endtask

  task automatic test_coef_extremes();
    logic [CFG_IDX_W-1:0] idx;
    set_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    for (int i = NCOEF; i < (1 << CFG_IDX_W); i++) begin
      idx = CFG_IDX_W'(i);
      write_coef(idx, rand_coef());
    end
    repeat (TAPS) send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample('1);
    send_sample(SW'(1));
    send_sample('0);
    wait_idle();
  endtask

  task automatic test_random_settings();
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
    for (int p = 0; p < 7; p++) begin
      if (p == 0)
        set_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
      else if (p == 1)
        set_coefs('0, '0, '0, '0, '0);
      else
        set_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
      // alternate lively and quiet stretches on both sides
      src_gaps_on    = (p % 3) != 2;
      sink_stalls_on = (p % 3) != 1;
      repeat (150) send_sample(rand_sample());
      wait_idle();
    end
  endtask

  task automatic test_output_backpressure();
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    set_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
    hold_request = 1'b1;
    repeat (40) send_sample(rand_sample());
    wait_idle();
  endtask

  task automatic test_streaming_full_rate();
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    set_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
    repeat (120) send_sample(rand_sample());
    wait_idle();
  endtask

  // receiver: random stall bursts, plus one long hold on request
  initial begin : sink_side
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && !in_tready)
      in_stall_cycles++;
  end

  always @(posedge clk) begin : check_filtered
    logic [OUT_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (filtered_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected none, actual %0d", $time,
                 $signed(out_tdata[OUT_W-1:0]));
      end else begin
        want = filtered_q.pop_front();
        results_checked++;
        if (out_tdata[OUT_W-1:0] !== want) begin
          errors++;
          $display("%0t: filtered_out mismatch, expected %0d, actual %0d", $time,
                   $signed(want), $signed(out_tdata[OUT_W-1:0]));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("fir_filter_fixed_point_q8_tb: FAIL");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    hold_request   = 1'b0;
    coef_model[CFG_COEF_OUTER]  = COEF_OUTER_RST;
    coef_model[CFG_COEF_SECOND] = COEF_SECOND_RST;
    coef_model[CFG_COEF_THIRD]  = COEF_THIRD_RST;
    coef_model[CFG_COEF_FOURTH] = COEF_FOURTH_RST;
    coef_model[CFG_COEF_CENTER] = COEF_CENTER_RST;
    for (int k = 0; k < TAPS - 1; k++)
      history[k] = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_default_response();
    test_coef_extremes();
    test_random_settings();
    test_output_backpressure();
    test_streaming_full_rate();

    $display("Covered %0d samples and %0d results over %0d coefficient settings,",
             samples_sent, results_checked, settings_used + 1);
    $display("with %0d cycles of input held back by a full pipeline.", in_stall_cycles);
    if (errors == 0)
      $display("fir_filter_fixed_point_q8_tb: PASS");
    else
      $display("fir_filter_fixed_point_q8_tb: FAIL");
    $finish;
  end

endmodule
